FILE: rtl/pcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the plate color classifier.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // Field widths
  localparam int ChanW   = 8;
  localparam int ColW    = 9;
  localparam int RowW    = 6;
  localparam int CountW  = 14;
  localparam int SumW    = 22;
  localparam int WidthW  = 9;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // Register map (index = paddr[2])
  localparam logic REG_USED_WIDTH = 1'b0;

  localparam logic [WidthW-1:0] USED_WIDTH_RESET = 9'd320;

  // Divide by 20 as multiply by reciprocal, exact for 9-bit widths
  localparam int Div20Recip = 3277;
  localparam int Div20Shift = 16;

  // Color test thresholds
  localparam logic [ChanW-1:0] MAX_CHAN_MIN = 8'd50;
  localparam logic [ChanW-1:0] SPREAD_MIN   = 8'd24;

  // Verdict evidence floor
  localparam logic [15:0] EVIDENCE_MIN = 16'd100;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};
  localparam logic [SumW-1:0]   SUM_MAX   = {SumW{1'b1}};

  typedef enum logic [1:0] {
    COLOR_NONE  = 2'd0,
    COLOR_BLUE  = 2'd1,
    COLOR_GREEN = 2'd2
  } color_e;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [ColW-1:0]  column;
    logic [RowW-1:0]  row;
    logic             last_pixel;
  } pixel_t;

  // Column window derived from used_width
  typedef struct packed {
    logic            width_ok;
    logic [ColW-1:0] left;
    logic [ColW-1:0] right;
  } window_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SumW-1:0]   blue;
    logic [SumW-1:0]   green;
  } totals_t;

endpackage

FILE: rtl/pcc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_cfg
// APB register for used_width; precomputes the column window at write time.
// ----------------------------------------------------------------------------
module pcc_cfg #(
  parameter int FRAME_WIDTH = 320
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcc_pkg::ApbAddrW-1:0]        paddr,
  input  logic [pcc_pkg::ApbDataW-1:0]        pwdata,
  output logic [pcc_pkg::ApbDataW-1:0]        prdata,
  output logic                                pready,
  output pcc_pkg::window_t                    win_o
);
  import pcc_pkg::*;

  localparam int FwW = $clog2(FRAME_WIDTH + 1) + 1;
  localparam int RstLeft = 320 / 20;
  localparam logic RstOk = (320 <= FRAME_WIDTH);

  logic [WidthW-1:0] used_width_q;
  window_t           win_q, win_d;
  logic              wr_en;
  logic [WidthW-1:0] wr_val;
  logic [21:0]       prod;
  logic [ColW-1:0]   left;

  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_USED_WIDTH);
  assign wr_val = pwdata[WidthW-1:0];
  assign prod   = 22'(wr_val) * 22'(Div20Recip);
  assign left   = ColW'(prod >> Div20Shift);

  always_comb begin
    win_d.left     = left;
    win_d.right    = wr_val - left;
    win_d.width_ok = (wr_val != '0) && (FwW'(wr_val) <= FwW'(FRAME_WIDTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_width_q   <= USED_WIDTH_RESET;
      win_q.width_ok <= RstOk;
      win_q.left     <= ColW'(RstLeft);
      win_q.right    <= ColW'(320 - RstLeft);
    end else if (wr_en) begin
      used_width_q <= wr_val;
      win_q        <= win_d;
    end
  end

  assign prdata = (paddr[2] == REG_USED_WIDTH) ? ApbDataW'(used_width_q) : '0;
  assign pready = 1'b1;
  assign win_o  = win_q;

endmodule

FILE: rtl/pcc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_accum
// Pixel test and saturating accumulators; hands crop totals to the verdict stage.
// ----------------------------------------------------------------------------
module pcc_accum #(
  parameter int FRAME_HEIGHT = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  input  pcc_pkg::pixel_t   pix_i,
  input  pcc_pkg::window_t  win_i,
  output logic              pix_pop_o,
  output logic              tot_valid_o,
  output pcc_pkg::totals_t  tot_o,
  input  logic              tot_pop_i
);
  import pcc_pkg::*;

  localparam int RowCmpW = 9;
  localparam logic [RowCmpW-1:0] RowTop    = RowCmpW'(FRAME_HEIGHT / 8);
  localparam logic [RowCmpW-1:0] RowBottom = RowCmpW'(FRAME_HEIGHT - FRAME_HEIGHT / 8);

  totals_t acc_q, acc_d;
  totals_t tot_q;
  logic    tot_valid_q;

  logic [ChanW-1:0] mx, mn, gr, br, spread, b_add, g_add;
  logic             in_win, colored, hit;
  logic [CountW:0]  cnt_sum;
  logic [SumW:0]    b_sum, g_sum;
  totals_t          acc_upd;

  always_comb begin
    mx = (pix_i.blue > pix_i.green) ? pix_i.blue : pix_i.green;
    mx = (mx > pix_i.red) ? mx : pix_i.red;
    mn = (pix_i.blue < pix_i.green) ? pix_i.blue : pix_i.green;
    mn = (mn < pix_i.red) ? mn : pix_i.red;
    spread  = mx - mn;
    colored = (mx >= MAX_CHAN_MIN) && (spread >= SPREAD_MIN);

    in_win = (pix_i.column >= win_i.left) && (pix_i.column < win_i.right) &&
             (RowCmpW'(pix_i.row) >= RowTop) && (RowCmpW'(pix_i.row) < RowBottom);
    hit = win_i.width_ok && in_win && colored;

    gr = (pix_i.green > pix_i.red) ? pix_i.green : pix_i.red;
    br = (pix_i.blue > pix_i.red) ? pix_i.blue : pix_i.red;
    b_add = (pix_i.blue > gr) ? pix_i.blue - gr : '0;
    g_add = (pix_i.green > br) ? pix_i.green - br : '0;

    cnt_sum = {1'b0, acc_q.count} + (CountW+1)'(1);
    b_sum   = {1'b0, acc_q.blue} + (SumW+1)'(b_add);
    g_sum   = {1'b0, acc_q.green} + (SumW+1)'(g_add);

    acc_upd = acc_q;
    if (hit) begin
      acc_upd.count = cnt_sum[CountW] ? COUNT_MAX : cnt_sum[CountW-1:0];
      acc_upd.blue  = b_sum[SumW] ? SUM_MAX : b_sum[SumW-1:0];
      acc_upd.green = g_sum[SumW] ? SUM_MAX : g_sum[SumW-1:0];
    end
  end

  // A last pixel waits only while the totals slot is full and not draining
  assign pix_pop_o = pix_valid_i && (!pix_i.last_pixel || !tot_valid_q || tot_pop_i);

  always_comb begin
    acc_d = acc_q;
    if (pix_pop_o) begin
      acc_d = pix_i.last_pixel ? '0 : acc_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      tot_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (pix_pop_o && pix_i.last_pixel) begin
        tot_valid_q <= 1'b1;
      end else if (tot_pop_i) begin
        tot_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_pop_o && pix_i.last_pixel) begin
      tot_q <= win_i.width_ok ? acc_upd : '0;
    end
  end

  assign tot_valid_o = tot_valid_q;
  assign tot_o       = tot_q;

endmodule

FILE: rtl/pcc_verdict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_verdict
// Evidence floor and 5:4 ratio tests; holds the result register.
// ----------------------------------------------------------------------------
module pcc_verdict (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tot_valid_i,
  input  pcc_pkg::totals_t            tot_i,
  output logic                        tot_pop_o,
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic [1:0]                  plate_color_o,
  output logic [pcc_pkg::CountW-1:0]  colored_count_o,
  output logic [pcc_pkg::SumW-1:0]    blue_total_o,
  output logic [pcc_pkg::SumW-1:0]    green_total_o
);
  import pcc_pkg::*;

  localparam int RatioW = SumW + 3;

  logic        valid_q;
  color_e      color_q, color_d;
  totals_t     tot_q;
  logic [15:0] floor_ev;
  logic [RatioW-1:0] b4, g4, b5, g5;

  always_comb begin
    floor_ev = {tot_i.count, 2'b00};
    if (floor_ev < EVIDENCE_MIN) begin
      floor_ev = EVIDENCE_MIN;
    end
    b4 = RatioW'({tot_i.blue, 2'b00});
    g4 = RatioW'({tot_i.green, 2'b00});
    b5 = b4 + RatioW'(tot_i.blue);
    g5 = g4 + RatioW'(tot_i.green);

    if (tot_i.count == '0) begin
      color_d = COLOR_NONE;
    end else if ((tot_i.blue < SumW'(floor_ev)) && (tot_i.green < SumW'(floor_ev))) begin
      color_d = COLOR_NONE;
    end else if (b4 >= g5) begin
      color_d = COLOR_BLUE;
    end else if (g4 >= b5) begin
      color_d = COLOR_GREEN;
    end else begin
      color_d = COLOR_NONE;
    end
  end

  assign tot_pop_o = tot_valid_i && (!valid_q || result_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (tot_pop_o) begin
      valid_q <= 1'b1;
    end else if (result_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tot_pop_o) begin
      color_q <= color_d;
      tot_q   <= tot_i;
    end
  end

  assign result_valid_o  = valid_q;
  assign plate_color_o   = color_q;
  assign colored_count_o = tot_q.count;
  assign blue_total_o    = tot_q.blue;
  assign green_total_o   = tot_q.green;

endmodule

FILE: rtl/plate_color_classifier_top.sv
`timescale 1ns / 1ps
// Path: a last pixel passes the input, totals and result registers in turn.
// Throughput: one pixel per cycle unless a last pixel is held; three register
//   stages (input, accumulator totals, result) decouple pixel and result sides.
// Reset: rst_ni clears all valid flags and accumulators and sets used_width
//   to 320; no clearing pass is needed.
// ----------------------------------------------------------------------------
// plate_color_classifier_top
// Streams plate crop pixels, counts colored pixels inside a centered window,
// sums blue and green dominance margins, and issues a blue/green/none verdict
// on the last pixel of each crop.
// ----------------------------------------------------------------------------
module plate_color_classifier_top #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration (APB)
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [pcc_pkg::ApbDataW-1:0]  pwdata,
  output logic [pcc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  // pixel request channel
  input  logic                          pixel_valid_i,
  output logic                          pixel_ready_o,
  input  logic [pcc_pkg::ChanW-1:0]     blue_i,
  input  logic [pcc_pkg::ChanW-1:0]     green_i,
  input  logic [pcc_pkg::ChanW-1:0]     red_i,
  input  logic [pcc_pkg::ColW-1:0]      column_i,
  input  logic [pcc_pkg::RowW-1:0]      row_i,
  input  logic                          last_pixel_i,
  // result channel
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [1:0]                    plate_color_o,
  output logic [pcc_pkg::CountW-1:0]    colored_count_o,
  output logic [pcc_pkg::SumW-1:0]      blue_total_o,
  output logic [pcc_pkg::SumW-1:0]      green_total_o
);
  import pcc_pkg::*;

  window_t win;
  pixel_t  pix_q;
  logic    pix_valid_q;
  logic    pix_pop;
  logic    pix_take;
  logic    tot_valid;
  totals_t tot;
  logic    tot_pop;

  // Column window bounds are recomputed on each used_width write, so the
  // per-pixel path only sees compares.
  pcc_cfg #(
    .FRAME_WIDTH(FRAME_WIDTH)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .win_o  (win)
  );

  // Input register. It refills in the same cycle it drains, so only a last
  // pixel blocked behind full downstream stages holds off new requests.
  assign pixel_ready_o = !pix_valid_q || pix_pop;
  assign pix_take      = pixel_valid_i && pixel_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (pix_take) begin
      pix_valid_q <= 1'b1;
    end else if (pix_pop) begin
      pix_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_take) begin
      pix_q.blue       <= blue_i;
      pix_q.green      <= green_i;
      pix_q.red        <= red_i;
      pix_q.column     <= column_i;
      pix_q.row        <= row_i;
      pix_q.last_pixel <= last_pixel_i;
    end
  end

  // Color test and saturating accumulation; on a last pixel the totals
  // (zeroed when the width is invalid) move to a holding register.
  pcc_accum #(
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_valid_i(pix_valid_q),
    .pix_i      (pix_q),
    .win_i      (win),
    .pix_pop_o  (pix_pop),
    .tot_valid_o(tot_valid),
    .tot_o      (tot),
    .tot_pop_i  (tot_pop)
  );

  // Verdict logic sits between the totals holding register and the
  // result register.
  pcc_verdict u_verdict (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tot_valid_i    (tot_valid),
    .tot_i          (tot),
    .tot_pop_o      (tot_pop),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .plate_color_o  (plate_color_o),
    .colored_count_o(colored_count_o),
    .blue_total_o   (blue_total_o),
    .green_total_o  (green_total_o)
  );

endmodule

FILE: test/tb_plate_color_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plate_color_classifier_top
// Streams plate crops through the classifier and checks every verdict and
// total against a predictor kept inside the bench. A short table of directed
// pixels comes first: window edges, color thresholds and ratio boundaries.
// Random crops follow, over several used_width settings and three
// back-pressure patterns.
// ----------------------------------------------------------------------------
module tb_plate_color_classifier_top;
  import pcc_pkg::*;

  // Frame geometry as built into the block
  localparam int FrameWidth  = 320;
  localparam int FrameHeight = 48;
  localparam int RowTop      = FrameHeight / 8;
  localparam int RowBottom   = FrameHeight - RowTop;

  // Colored-pixel test and saturation limits
  localparam int unsigned ColorMaxMin = 50;
  localparam int unsigned ColorSpread = 24;
  localparam int unsigned CountSat    = 16383;
  localparam int unsigned SumSat      = 4194303;

  // Register address of used_width
  localparam logic [ApbAddrW-1:0] UsedWidthAddr = {REG_USED_WIDTH, 2'b00};

  // Settle time after the last verdict comes back, with margin to spare
  localparam int SettleCycles = 8;

  localparam int RandomItems    = 950;
  localparam int NumSegments    = 11;
  localparam int MaxReports     = 10;

  // Width per random segment: nominal, invalid (zero and above frame), and
  // the small widths where the margin goes from 0 to 1 column, plus other valid widths
  localparam int WidthPlan [NumSegments] = '{320, 0, 19, 20, 1, 511, 321, 160, 319, 40, 320};

  typedef struct packed {
    color_e            color;
    logic [CountW-1:0] count;
    logic [SumW-1:0]   blue;
    logic [SumW-1:0]   green;
  } plate_result_t;

  // One directed pixel; fixed rows carry a hand-written verdict
  typedef struct packed {
    pixel_t        px;
    logic          fixed;
    plate_result_t res;
  } stim_row_t;

  localparam plate_result_t ZeroVerdict = '{COLOR_NONE, 14'd0, 22'd0, 22'd0};
  localparam int NumDirected = 25;

  // Directed table, walked with used_width at its reset value (window is
  // columns 16..303, rows 6..41)
  localparam stim_row_t DirectedRows [NumDirected] = '{
    // last pixel straight after reset: empty crop
    '{'{8'd0,   8'd0,   8'd0,   9'd0,   6'd0,  1'b1}, 1'b1, ZeroVerdict},
    // colored pixels just outside each window edge, then beyond the frame
    '{'{8'd255, 8'd0,   8'd0,   9'd15,  6'd6,  1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd255, 8'd0,   8'd0,   9'd304, 6'd41, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd0,   8'd255, 8'd0,   9'd16,  6'd5,  1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd0,   8'd255, 8'd0,   9'd303, 6'd42, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd255, 8'd0,   8'd0,   9'd511, 6'd63, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd255, 8'd0,   8'd0,   9'd319, 6'd0,  1'b1}, 1'b1, ZeroVerdict},
    // single pure pixels on the window corners
    '{'{8'd255, 8'd0,   8'd0,   9'd16,  6'd6,  1'b1}, 1'b1,
      '{COLOR_BLUE, 14'd1, 22'd255, 22'd0}},
    '{'{8'd0,   8'd255, 8'd0,   9'd303, 6'd41, 1'b1}, 1'b1,
      '{COLOR_GREEN, 14'd1, 22'd0, 22'd255}},
    // max channel one below threshold, spread one below threshold
    '{'{8'd49,  8'd0,   8'd0,   9'd100, 6'd20, 1'b1}, 1'b1, ZeroVerdict},
    '{'{8'd50,  8'd27,  8'd27,  9'd100, 6'd20, 1'b1}, 1'b1, ZeroVerdict},
    // both thresholds met exactly, evidence too thin
    '{'{8'd50,  8'd26,  8'd26,  9'd100, 6'd20, 1'b1}, 1'b1,
      '{COLOR_NONE, 14'd1, 22'd24, 22'd0}},
    // red dominant, blue/green tie: counted, no margins
    '{'{8'd0,   8'd0,   8'd255, 9'd100, 6'd20, 1'b1}, 1'b1,
      '{COLOR_NONE, 14'd1, 22'd0, 22'd0}},
    '{'{8'd200, 8'd200, 8'd0,   9'd100, 6'd20, 1'b1}, 1'b1,
      '{COLOR_NONE, 14'd1, 22'd0, 22'd0}},
    // same coordinates three times
    '{'{8'd255, 8'd0,   8'd0,   9'd50,  6'd10, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd255, 8'd0,   8'd0,   9'd50,  6'd10, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd0,   8'd255, 8'd0,   9'd50,  6'd10, 1'b1}, 1'b0, ZeroVerdict},
    // blue 125 vs green 100: blue exactly at 5:4
    '{'{8'd175, 8'd50,  8'd0,   9'd120, 6'd30, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd0,   8'd150, 8'd50,  9'd121, 6'd30, 1'b1}, 1'b0, ZeroVerdict},
    // blue 100 vs green 125: green exactly at 5:4
    '{'{8'd150, 8'd0,   8'd50,  9'd120, 6'd30, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd50,  8'd175, 8'd0,   9'd121, 6'd30, 1'b1}, 1'b0, ZeroVerdict},
    // blue 110 vs green 120: inside the ratio band
    '{'{8'd160, 8'd50,  8'd0,   9'd120, 6'd30, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd0,   8'd170, 8'd50,  9'd121, 6'd30, 1'b1}, 1'b0, ZeroVerdict},
    // blue sum lands exactly on the evidence floor of 100
    '{'{8'd80,  8'd30,  8'd30,  9'd200, 6'd25, 1'b0}, 1'b0, ZeroVerdict},
    '{'{8'd80,  8'd30,  8'd30,  9'd200, 6'd25, 1'b1}, 1'b0, ZeroVerdict}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  logic               pixel_valid_i = 1'b0;
  logic               pixel_ready_o;
  logic [ChanW-1:0]   blue_i        = '0;
  logic [ChanW-1:0]   green_i       = '0;
  logic [ChanW-1:0]   red_i         = '0;
  logic [ColW-1:0]    column_i      = '0;
  logic [RowW-1:0]    row_i         = '0;
  logic               last_pixel_i  = 1'b0;

  logic               result_valid_o;
  logic               result_ready_i = 1'b0;
  logic [1:0]         plate_color_o;
  logic [CountW-1:0]  colored_count_o;
  logic [SumW-1:0]    blue_total_o;
  logic [SumW-1:0]    green_total_o;

  // Predictor state: register mirror and per-crop tallies
  int unsigned cfg_width = 320;
  int unsigned tally_count;
  int unsigned tally_blue;
  int unsigned tally_green;

  plate_result_t pending_verdicts [$];
  plate_result_t due_verdict;

  // Idle odds in percent, changed between phases
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 57;

  int mismatch_count;
  int pixels_sent;
  int verdicts_seen;
  int blue_seen;
  int green_seen;
  int none_seen;

  plate_color_classifier_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .blue_i         (blue_i),
    .green_i        (green_i),
    .red_i          (red_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .last_pixel_i   (last_pixel_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .plate_color_o  (plate_color_o),
    .colored_count_o(colored_count_o),
    .blue_total_o   (blue_total_o),
    .green_total_o  (green_total_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Verdict rule: floor of max(100, 4*count), then the 5:4 ratio tests
  function automatic color_e judge_color(longint unsigned cnt, longint unsigned b,
                                         longint unsigned g);
    longint unsigned evidence_floor;
    if (cnt == 0) return COLOR_NONE;
    evidence_floor = (cnt * 4 < 100) ? 100 : cnt * 4;
    if (b < evidence_floor && g < evidence_floor) return COLOR_NONE;
    if (b * 4 >= g * 5) return COLOR_BLUE;
    if (g * 4 >= b * 5) return COLOR_GREEN;
    return COLOR_NONE;
  endfunction

  function automatic int unsigned sat_sum(int unsigned acc, int unsigned add,
                                          int unsigned lim);
    return (acc + add > lim) ? lim : acc + add;
  endfunction

  // Advances the tallies by one pixel; returns 1 when the pixel closes a crop
  function automatic bit classify_pixel(input pixel_t px, output plate_result_t res);
    int unsigned margin;
    int unsigned mx;
    int unsigned mn;
    int unsigned gr;
    int unsigned br;
    bit width_ok;
    width_ok = (cfg_width != 0) && (cfg_width <= FrameWidth);
    res = ZeroVerdict;
    if (width_ok) begin
      margin = cfg_width / 20;
      if (px.column >= margin && px.column < cfg_width - margin &&
          px.row >= RowTop && px.row < RowBottom) begin
        mx = px.blue;
        if (px.green > mx) mx = px.green;
        if (px.red > mx) mx = px.red;
        mn = px.blue;
        if (px.green < mn) mn = px.green;
        if (px.red < mn) mn = px.red;
        if (mx >= ColorMaxMin && mx - mn >= ColorSpread) begin
          gr = (px.green > px.red) ? px.green : px.red;
          br = (px.blue > px.red) ? px.blue : px.red;
          tally_count = sat_sum(tally_count, 1, CountSat);
          if (px.blue > gr) tally_blue = sat_sum(tally_blue, px.blue - gr, SumSat);
          if (px.green > br) tally_green = sat_sum(tally_green, px.green - br, SumSat);
        end
      end
    end
    if (!px.last_pixel) return 1'b0;
    if (width_ok) begin
      res.color = judge_color(tally_count, tally_blue, tally_green);
      res.count = CountW'(tally_count);
      res.blue  = SumW'(tally_blue);
      res.green = SumW'(tally_green);
    end
    tally_count = 0;
    tally_blue  = 0;
    tally_green = 0;
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  // Sends one pixel request, waits for acceptance, then books a verdict if it ends a crop
  task automatic send_pixel(input pixel_t px, input logic fixed, input plate_result_t res);
    plate_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    blue_i        <= px.blue;
    green_i       <= px.green;
    red_i         <= px.red;
    column_i      <= px.column;
    row_i         <= px.row;
    last_pixel_i  <= px.last_pixel;
    @(posedge clk_i);
    while (!pixel_ready_o) @(posedge clk_i);
    pixels_sent++;
    if (classify_pixel(px, predicted)) begin
      if (fixed) predicted = res;
      pending_verdicts = {pending_verdicts, predicted};
    end
  endtask

  // Stop sending, let every verdict come back and the pipeline empty
  task automatic drain_verdicts();
    pixel_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One APB setup+access pair; psel stays high for a following transfer
  task automatic apb_cycle(input logic wr, input logic [ApbDataW-1:0] data,
                           output logic [ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= UsedWidthAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
  endtask

  // Write used_width (junk in the unused upper bits) and read it back
  task automatic set_used_width(input logic [WidthW-1:0] w);
    logic [ApbDataW-1:0] data;
    logic [ApbDataW-1:0] rdata;
    data = $urandom();
    data[WidthW-1:0] = w;
    apb_cycle(1'b1, data, rdata);
    apb_cycle(1'b0, data, rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_width = w;
    compare_field("used_width readback", w, rdata[WidthW-1:0]);
  endtask

  // Random pixel. Tint 0 leans blue, 1 green, 2 either; 3 or a rare draw
  // gives a fully random pixel anywhere in the coordinate space.
  function automatic pixel_t make_pixel(int unsigned tint);
    pixel_t px;
    int unsigned margin;
    int unsigned hi;
    if (tint == 3 || $urandom_range(15) == 0) begin
      px.blue   = ChanW'($urandom());
      px.green  = ChanW'($urandom());
      px.red    = ChanW'($urandom());
      px.column = ColW'($urandom());
      px.row    = RowW'($urandom());
    end else begin
      margin = cfg_width / 20;
      if (cfg_width != 0 && cfg_width <= FrameWidth)
        px.column = ColW'($urandom_range(cfg_width - margin - 1, margin));
      else
        px.column = ColW'($urandom_range(FrameWidth - 1, 0));
      px.row = RowW'($urandom_range(RowBottom - 1, RowTop));
      if (tint == 2) tint = $urandom_range(1, 0);
      hi = $urandom_range(255, 40);
      px.red = ChanW'($urandom_range(hi, 0));
      if (tint == 0) begin
        px.blue  = ChanW'(hi);
        px.green = ChanW'($urandom_range(hi, 0));
      end else begin
        px.green = ChanW'(hi);
        px.blue  = ChanW'($urandom_range(hi, 0));
      end
    end
    px.last_pixel = 1'b0;
    return px;
  endfunction

  // Result side: random back-pressure, every accepted verdict checked
  // against the oldest booked one
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: verdict with none pending (color %0d, count %0d)",
                   $realtime, plate_color_o, colored_count_o);
      end else begin
        due_verdict = pending_verdicts.pop_front();
        verdicts_seen++;
        case (due_verdict.color)
          COLOR_BLUE:  blue_seen++;
          COLOR_GREEN: green_seen++;
          default:     none_seen++;
        endcase
        compare_field("plate_color", due_verdict.color, plate_color_o);
        compare_field("colored_count", due_verdict.count, colored_count_o);
        compare_field("blue_total", due_verdict.blue, blue_total_o);
        compare_field("green_total", due_verdict.green, green_total_o);
      end
    end
    result_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    pixel_t px;
    int unsigned crop_len;
    int unsigned tint;
    int seg_items;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset width of 320
    foreach (DirectedRows[i])
      send_pixel(DirectedRows[i].px, DirectedRows[i].fixed, DirectedRows[i].res);

    // Random crops, one width per segment. The drain before each write
    // doubles as the sender pause that waits out every pending verdict.
    for (int seg = 0; seg < NumSegments; seg++) begin
      drain_verdicts();
      if (seg == 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 32;
      end else if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_used_width(WidthW'(WidthPlan[seg]));
      seg_items = 0;
      while (seg_items < RandomItems / NumSegments) begin
        // mostly short crops so verdicts come often, now and then a longer one
        crop_len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        tint = $urandom_range(3, 0);
        for (int unsigned k = 0; k < crop_len; k++) begin
          px = make_pixel(tint);
          // noise crops may also break early on a stray last flag
          px.last_pixel = (k == crop_len - 1) || (tint == 3 && $urandom_range(7) == 0);
          send_pixel(px, 1'b0, ZeroVerdict);
          seg_items++;
        end
      end
    end

    drain_verdicts();

    $display("Run covered %0d pixels and %0d crop verdicts (%0d blue, %0d green, %0d none)",
             pixels_sent, verdicts_seen, blue_seen, green_seen, none_seen);
    $display("over %0d width settings incl. invalid ones, three stall patterns, %0d mismatches",
             NumSegments, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
